FILE: hdl/gsd_pkg.sv
`timescale 1ns / 1ps

package gsd_pkg;

  // top gear of the gearbox, no upshift from here on
  localparam int unsigned GearCount = 6;

  // field widths
  localparam int unsigned SpeedW  = 15;
  localparam int unsigned GearW   = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned AccelW  = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 63;
  localparam int unsigned RatioW  = 9;
  localparam int unsigned MinRpmW = 8;
  localparam int unsigned TblN    = 7;

  // rotational speeds compared in Q20 rad/s
  localparam int unsigned OmegaW      = 31;
  localparam int unsigned RpmToQ20    = 109807;
  localparam int unsigned MinRpmUnit  = 50;
  localparam int unsigned MinUnitQ20  = MinRpmUnit * RpmToQ20;
  localparam int unsigned InitSpeedQ4 = 800;
  localparam int unsigned AccCutRpm   = 2000;
  localparam int unsigned AccCutQ20   = AccCutRpm * RpmToQ20;
  localparam int unsigned AccCutSpeed = 1280;

  // register reset values
  localparam int unsigned UpperRpmRst  = 4800;
  localparam int unsigned CutRpmRst    = 8000;
  localparam int unsigned MarginRpmRst = 450;
  localparam int unsigned WaitMsRst    = 420;
  localparam int unsigned RetryMsRst   = 450;
  localparam int unsigned SafetyRst    = 154;
  localparam int unsigned UbRst        = UpperRpmRst * RpmToQ20;
  localparam int unsigned CutRst       = CutRpmRst * RpmToQ20;
  localparam int unsigned MkRst        = MarginRpmRst * RpmToQ20;
  localparam int unsigned ThrRst       = UbRst - MkRst;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUpperRpm  = 3'd0,
    CfgCutRpm    = 3'd1,
    CfgMarginRpm = 3'd2,
    CfgWaitMs    = 3'd3,
    CfgRetryMs   = 3'd4,
    CfgSafety    = 3'd5,
    CfgRatioTbl  = 3'd6,
    CfgMinRpmTbl = 3'd7
  } cfg_idx_e;

  // configuration as seen by the evaluation logic, speeds already in Q20
  typedef struct packed {
    logic [OmegaW-1:0]          ub;
    logic [OmegaW-1:0]          cut;
    logic [31:0]                thr;       // two's complement, ub - margin
    logic [15:0]                wait_ms;
    logic [15:0]                retry_ms;
    logic [7:0]                 sf;
    logic [TblN*RatioW-1:0]     ratio;
    logic [TblN*MinRpmW-1:0]    min_rpm;
  } gsd_cfg_t;

  // per-word conditions that do not depend on state
  typedef struct packed {
    logic ge_ub;
    logic ge_cut;
    logic le_lb;
    logic lat_high;
    logic accel_cut;
    logic revs_ok;
    logic down_flag;
    logic init_speed;
  } gsd_flags_t;

  // ratio entry, zero for the unused code
  function automatic logic [RatioW-1:0] ratio_sel(logic [TblN*RatioW-1:0] tbl,
                                                  logic [GearW-1:0] idx);
    logic [RatioW-1:0] r;
    r = '0;
    for (int i = 0; i < TblN; i++) begin
      if (idx == GearW'(i)) r = tbl[i*RatioW +: RatioW];
    end
    return r;
  endfunction

  // minimum speed entry, gear seven uses the last entry
  function automatic logic [MinRpmW-1:0] min_sel(logic [TblN*MinRpmW-1:0] tbl,
                                                 logic [GearW-1:0] idx);
    logic [MinRpmW-1:0] r;
    r = tbl[(TblN-1)*MinRpmW +: MinRpmW];
    for (int i = 0; i < TblN; i++) begin
      if (idx == GearW'(i)) r = tbl[i*MinRpmW +: MinRpmW];
    end
    return r;
  endfunction

endpackage

FILE: hdl/gear_shift_decider.sv
`timescale 1ns / 1ps
// a word waits in the input register while the result register is full
// throughput: one word per cycle while out_stall_i is low; the decision logic
//   between the input register and the result register is a single pass, with
//   the gear state updated as the word leaves the input register
// reset: asynchronous, active low; clears the latched mark, requested gear and
//   request time, restores register defaults and empties both word registers
module gear_shift_decider import gsd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  // input word
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [SpeedW-1:0]         engine_speed_i,
  input  logic [GearW-1:0]          current_gear_i,
  input  logic [TimeW-1:0]          now_ms_i,
  input  logic signed [AccelW-1:0]  lateral_accel_i,
  input  logic signed [AccelW-1:0]  lat_limit_max_i,
  input  logic signed [AccelW-1:0]  lat_limit_min_i,
  input  logic signed [AccelW-1:0]  target_long_accel_i,
  input  logic [SpeedW-1:0]         target_speed_i,
  input  logic                      predicted_downshift_i,
  input  logic                      have_trajectory_i,
  // result word
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [GearW-1:0]          gear_cmd_o,
  output logic                      shift_req_o,
  output logic                      cut_shift_req_o,
  output logic                      is_initialized_o
);

  gsd_cfg_t   cfg;
  gsd_flags_t flags;

  // input register
  logic                      in_vld_q, in_vld_d;
  logic [SpeedW-1:0]         es_q;
  logic [GearW-1:0]          gear_q;
  logic [TimeW-1:0]          now_q;
  logic signed [AccelW-1:0]  ay_q, lmax_q, lmin_q, ax_q;
  logic [SpeedW-1:0]         vt_q;
  logic                      pred_q, traj_q;

  // gear state
  logic                 latched_q, latched_d;
  logic [GearW-1:0]     req_q, req_d;
  logic [TimeW-1:0]     lrt_q, lrt_d;

  // result register
  logic                 out_vld_q, out_vld_d;
  logic [GearW-1:0]     gear_cmd_q, gear_cmd_d;
  logic                 shift_q, shift_d;
  logic                 cutreq_q, cutreq_d;
  logic                 init_q, init_d;

  logic in_take, advance, out_free;

  // working values for the decision
  logic              latch_now, lat_eff;
  logic [GearW-1:0]  req0;
  logic [TimeW-1:0]  lrt0, elapsed;

  gsd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  gsd_eval u_eval (
    .cfg_i                 (cfg),
    .engine_speed_i        (es_q),
    .current_gear_i        (gear_q),
    .lateral_accel_i       (ay_q),
    .lat_limit_max_i       (lmax_q),
    .lat_limit_min_i       (lmin_q),
    .target_long_accel_i   (ax_q),
    .target_speed_i        (vt_q),
    .predicted_downshift_i (pred_q),
    .have_trajectory_i     (traj_q),
    .flags_o               (flags)
  );

  // handshake: the result register frees up when it is empty or being taken
  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (advance) in_vld_d = 1'b0;
    if (in_take) in_vld_d = 1'b1;
    out_vld_d = out_vld_q;
    if (!out_stall_i) out_vld_d = 1'b0;
    if (advance) out_vld_d = 1'b1;
  end

  // gear decision for the word in the input register
  always_comb begin
    latch_now = flags.init_speed && !latched_q;
    lat_eff   = latched_q || latch_now;
    req0      = latch_now ? gear_q : req_q;
    lrt0      = latch_now ? now_q : lrt_q;
    elapsed   = now_q - lrt0;      // wraps with the free-running time

    req_d     = req0;
    lrt_d     = lrt0;
    shift_d   = 1'b0;
    cutreq_d  = 1'b0;

    if (lat_eff) begin
      if (elapsed >= TimeW'(cfg.wait_ms)) begin
        if (flags.ge_ub && (gear_q < GearW'(GearCount))) begin
          // upshift, held back by lateral load unless revs reach the cut speed
          shift_d = 1'b1;
          if (flags.lat_high) begin
            if (flags.ge_cut) req_d = gear_q + 3'd1;
            else              cutreq_d = 1'b1;
          end else begin
            req_d = gear_q + 3'd1;
            lrt_d = now_q;
          end
        end else if ((flags.le_lb || flags.down_flag) && (gear_q > 3'd1)) begin
          // downshift only if the revs stay below the limiter margin
          if (flags.revs_ok) begin
            shift_d = 1'b1;
            if (flags.lat_high || flags.accel_cut) begin
              cutreq_d = 1'b1;
            end else begin
              req_d = gear_q - 3'd1;
              lrt_d = now_q;
            end
          end
        end
      end else if ((elapsed >= TimeW'(cfg.retry_ms)) && (req0 != gear_q)) begin
        // unfulfilled request falls back to the engaged gear
        req_d = gear_q;
      end
    end

    latched_d  = lat_eff;
    gear_cmd_d = lat_eff ? req_d : gear_q;
    init_d     = lat_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      latched_q <= 1'b0;
      req_q     <= '0;
      lrt_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        latched_q <= latched_d;
        req_q     <= req_d;
        lrt_q     <= lrt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      es_q   <= engine_speed_i;
      gear_q <= current_gear_i;
      now_q  <= now_ms_i;
      ay_q   <= lateral_accel_i;
      lmax_q <= lat_limit_max_i;
      lmin_q <= lat_limit_min_i;
      ax_q   <= target_long_accel_i;
      vt_q   <= target_speed_i;
      pred_q <= predicted_downshift_i;
      traj_q <= have_trajectory_i;
    end
    if (advance) begin
      gear_cmd_q <= gear_cmd_d;
      shift_q    <= shift_d;
      cutreq_q   <= cutreq_d;
      init_q     <= init_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign gear_cmd_o       = gear_cmd_q;
  assign shift_req_o      = shift_q;
  assign cut_shift_req_o  = cutreq_q;
  assign is_initialized_o = init_q;

  // once latched the block stays latched until reset
  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q |=> latched_q)
    else $error("latched mark dropped");

  // a held-back shift is always a wanted shift
  a_cut_implies_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && cutreq_q |-> shift_q)
    else $error("cut request without shift request");

  // no shift decisions before the engine has started
  a_no_shift_uninit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !init_q |-> !shift_q && !cutreq_q)
    else $error("shift request before initialization");

  // the input side stalls only behind a full result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_vld_q && out_stall_i && in_vld_q)
    else $error("input stalled without a blocked result");

endmodule

FILE: hdl/gsd_cfg.sv
`timescale 1ns / 1ps

module gsd_cfg import gsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output gsd_cfg_t           cfg_o
);

  logic [OmegaW-1:0] ub_q, ub_d, cut_q, cut_d;
  logic [OmegaW-3:0] mk_q, mk_d;
  logic [31:0]       thr_q, thr_d;
  logic [15:0]       wait_q, wait_d, retry_q, retry_d;
  logic [7:0]        sf_q, sf_d;
  logic [TblN*RatioW-1:0]  ratio_q, ratio_d;
  logic [TblN*MinRpmW-1:0] minrpm_q, minrpm_d;

  logic [OmegaW-1:0] ub_new, cut_new;
  logic [OmegaW-3:0] mk_new;

  // rpm to Q20 conversion at write time
  assign ub_new  = OmegaW'(cfg_data_i[13:0]) * OmegaW'(RpmToQ20);
  assign cut_new = OmegaW'(cfg_data_i[13:0]) * OmegaW'(RpmToQ20);
  assign mk_new  = (OmegaW-2)'(cfg_data_i[11:0]) * (OmegaW-2)'(RpmToQ20);

  always_comb begin
    ub_d     = ub_q;
    cut_d    = cut_q;
    mk_d     = mk_q;
    thr_d    = thr_q;
    wait_d   = wait_q;
    retry_d  = retry_q;
    sf_d     = sf_q;
    ratio_d  = ratio_q;
    minrpm_d = minrpm_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgUpperRpm: begin
          ub_d  = ub_new;
          thr_d = 32'(ub_new) - 32'(mk_q);
        end
        CfgCutRpm: cut_d = cut_new;
        CfgMarginRpm: begin
          mk_d  = mk_new;
          thr_d = 32'(ub_q) - 32'(mk_new);
        end
        CfgWaitMs:    wait_d   = cfg_data_i[15:0];
        CfgRetryMs:   retry_d  = cfg_data_i[15:0];
        CfgSafety:    sf_d     = cfg_data_i[7:0];
        CfgRatioTbl:  ratio_d  = cfg_data_i[TblN*RatioW-1:0];
        CfgMinRpmTbl: minrpm_d = cfg_data_i[TblN*MinRpmW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ub_q     <= OmegaW'(UbRst);
      cut_q    <= OmegaW'(CutRst);
      mk_q     <= (OmegaW-2)'(MkRst);
      thr_q    <= 32'(ThrRst);
      wait_q   <= 16'(WaitMsRst);
      retry_q  <= 16'(RetryMsRst);
      sf_q     <= 8'(SafetyRst);
      ratio_q  <= '0;
      minrpm_q <= '0;
    end else begin
      ub_q     <= ub_d;
      cut_q    <= cut_d;
      mk_q     <= mk_d;
      thr_q    <= thr_d;
      wait_q   <= wait_d;
      retry_q  <= retry_d;
      sf_q     <= sf_d;
      ratio_q  <= ratio_d;
      minrpm_q <= minrpm_d;
    end
  end

  assign cfg_o.ub       = ub_q;
  assign cfg_o.cut      = cut_q;
  assign cfg_o.thr      = thr_q;
  assign cfg_o.wait_ms  = wait_q;
  assign cfg_o.retry_ms = retry_q;
  assign cfg_o.sf       = sf_q;
  assign cfg_o.ratio    = ratio_q;
  assign cfg_o.min_rpm  = minrpm_q;

endmodule

FILE: hdl/gsd_eval.sv
`timescale 1ns / 1ps

module gsd_eval import gsd_pkg::*; (
  input  gsd_cfg_t                   cfg_i,
  input  logic [SpeedW-1:0]          engine_speed_i,
  input  logic [GearW-1:0]           current_gear_i,
  input  logic signed [AccelW-1:0]   lateral_accel_i,
  input  logic signed [AccelW-1:0]   lat_limit_max_i,
  input  logic signed [AccelW-1:0]   lat_limit_min_i,
  input  logic signed [AccelW-1:0]   target_long_accel_i,
  input  logic [SpeedW-1:0]          target_speed_i,
  input  logic                       predicted_downshift_i,
  input  logic                       have_trajectory_i,
  output gsd_flags_t                 flags_o
);

  logic [OmegaW-1:0] omega, lb;
  logic [MinRpmW-1:0] min_ent;
  logic [RatioW-1:0] ra, rb;
  logic [AccelW-1:0] ay_abs, lmax_abs, lmin_abs, lim_abs;
  logic [AccelW+7:0] ay_scaled, lim;
  logic [OmegaW+RatioW-1:0] lhs_u;
  logic signed [OmegaW+RatioW+1:0] lhs, rhs, thr_x, rb_x;

  assign omega = {engine_speed_i, 16'd0};

  // lower bound of the reported gear
  assign min_ent = min_sel(cfg_i.min_rpm, current_gear_i);
  assign lb      = OmegaW'(min_ent) * OmegaW'(MinUnitQ20);

  // lateral load against the scaled tighter limit
  assign ay_abs    = lateral_accel_i[AccelW-1] ? AccelW'(-lateral_accel_i) : lateral_accel_i;
  assign lmax_abs  = lat_limit_max_i[AccelW-1] ? AccelW'(-lat_limit_max_i) : lat_limit_max_i;
  assign lmin_abs  = lat_limit_min_i[AccelW-1] ? AccelW'(-lat_limit_min_i) : lat_limit_min_i;
  assign lim_abs   = (lmax_abs < lmin_abs) ? lmax_abs : lmin_abs;
  assign lim       = have_trajectory_i ? ((AccelW+8)'(lim_abs) * (AccelW+8)'(cfg_i.sf)) : '0;
  assign ay_scaled = {ay_abs, 8'd0};

  // revs after a downshift, cross-multiplied against the ratio
  assign ra    = ratio_sel(cfg_i.ratio, current_gear_i - 3'd2);
  assign rb    = ratio_sel(cfg_i.ratio, current_gear_i - 3'd1);
  assign lhs_u = {(SpeedW+RatioW)'(engine_speed_i) * (SpeedW+RatioW)'(ra), 16'd0};
  assign lhs   = $signed({2'b00, lhs_u});
  assign thr_x = (OmegaW+RatioW+2)'($signed(cfg_i.thr));
  assign rb_x  = $signed({{(OmegaW+2){1'b0}}, rb});
  assign rhs   = thr_x * rb_x;

  assign flags_o.ge_ub      = omega >= cfg_i.ub;
  assign flags_o.ge_cut     = omega >= cfg_i.cut;
  assign flags_o.le_lb      = omega <= lb;
  assign flags_o.lat_high   = ay_scaled > lim;
  assign flags_o.accel_cut  = have_trajectory_i && !target_long_accel_i[AccelW-1] &&
                              (target_long_accel_i != '0) &&
                              (omega > OmegaW'(AccCutQ20)) &&
                              (target_speed_i > SpeedW'(AccCutSpeed));
  assign flags_o.revs_ok    = (rb != '0) && (lhs <= rhs);
  assign flags_o.down_flag  = have_trajectory_i && predicted_downshift_i;
  assign flags_o.init_speed = engine_speed_i > SpeedW'(InitSpeedQ4);

endmodule

FILE: verif/tb_gear_shift_decider.sv
`timescale 1ns / 1ps

module tb_gear_shift_decider;
  import gsd_pkg::*;

  // q20 rad/s per rpm, kept signed so that negative thresholds compare right
  localparam longint Q20 = longint'(RpmToQ20);
  localparam int CycleLimit = 400000;
  localparam int PhaseWords = 179;

  // road-like tables: ratios fall with the gear, the gear seven ratio is left at
  // zero so that a downshift from seven always fails its rev check
  localparam logic [TblN*RatioW-1:0] RoadRatios =
    {9'd0, 9'd122, 9'd141, 9'd173, 9'd218, 9'd282, 9'd384};
  localparam logic [TblN*MinRpmW-1:0] RoadMinRpm =
    {8'd45, 8'd44, 8'd42, 8'd40, 8'd38, 8'd30, 8'd20};

  // one control tick as offered to the block
  typedef struct {
    logic [SpeedW-1:0]        engine_speed;
    logic [GearW-1:0]         current_gear;
    logic [TimeW-1:0]         now_ms;
    logic signed [AccelW-1:0] lateral_accel;
    logic signed [AccelW-1:0] lat_limit_max;
    logic signed [AccelW-1:0] lat_limit_min;
    logic signed [AccelW-1:0] target_long_accel;
    logic [SpeedW-1:0]        target_speed;
    logic                     predicted_downshift;
    logic                     have_trajectory;
  } tick_t;

  // the decision that comes back for one tick
  typedef struct {
    logic [GearW-1:0] gear_cmd;
    logic             shift_req;
    logic             cut_shift_req;
    logic             is_initialized;
  } decision_t;

  // shadow of the shift logic plus the decisions still owed by the block
  class gear_decision_board;
    // register copies
    logic [13:0]             upper_rpm;
    logic [13:0]             cut_rpm;
    logic [11:0]             margin_rpm;
    logic [15:0]             wait_ms;
    logic [15:0]             retry_ms;
    logic [7:0]              safety;
    logic [TblN*RatioW-1:0]  ratio_tbl;
    logic [TblN*MinRpmW-1:0] min_tbl;
    // gear state
    logic [GearW-1:0]        req_gear;
    bit                      latched;
    logic [TimeW-1:0]        last_req_ms;
    decision_t               decisions_due[$];
    int                      errors;
    int                      checked;
    int                      shifts;
    int                      held;
    int                      reverts;

    function new();
      upper_rpm   = UpperRpmRst;
      cut_rpm     = CutRpmRst;
      margin_rpm  = MarginRpmRst;
      wait_ms     = WaitMsRst;
      retry_ms    = RetryMsRst;
      safety      = SafetyRst;
      ratio_tbl   = '0;
      min_tbl     = '0;
      req_gear    = '0;
      latched     = 1'b0;
      last_req_ms = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgW-1:0] d);
      case (idx)
        CfgUpperRpm:  upper_rpm  = d[13:0];
        CfgCutRpm:    cut_rpm    = d[13:0];
        CfgMarginRpm: margin_rpm = d[11:0];
        CfgWaitMs:    wait_ms    = d[15:0];
        CfgRetryMs:   retry_ms   = d[15:0];
        CfgSafety:    safety     = d[7:0];
        CfgRatioTbl:  ratio_tbl  = d[TblN*RatioW-1:0];
        CfgMinRpmTbl: min_tbl    = d[TblN*MinRpmW-1:0];
        default: ;
      endcase
    endfunction

    function longint mag(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // runs the gear decision for an accepted tick and queues the outcome
    function void note_tick(tick_t w);
      longint    omega, ub, lb, cutq, lim, a, b, thr, ra, rb, ax;
      int        gi, lb_idx;
      logic [TimeW-1:0] elapsed;
      bit        lat_high, accel_cut, down_flag, shift, hold;
      decision_t d;
      gi     = int'(w.current_gear);
      omega  = longint'(w.engine_speed) << 16;
      ub     = longint'(upper_rpm) * Q20;
      cutq   = longint'(cut_rpm) * Q20;
      lb_idx = (gi > 6) ? 6 : gi;
      lb     = longint'(min_tbl[lb_idx*MinRpmW +: MinRpmW]) * longint'(MinRpmUnit) * Q20;
      ax     = longint'(w.target_long_accel);
      // lateral limit is the tighter constraint scaled by the safety factor
      lim = 0;
      if (w.have_trajectory) begin
        a   = mag(longint'(w.lat_limit_max));
        b   = mag(longint'(w.lat_limit_min));
        lim = ((a < b) ? a : b) * longint'(safety);
      end
      lat_high  = mag(longint'(w.lateral_accel)) * 256 > lim;
      accel_cut = w.have_trajectory && ax > 0 && omega > longint'(AccCutRpm) * Q20 &&
                  longint'(w.target_speed) > longint'(AccCutSpeed);
      down_flag = w.have_trajectory && w.predicted_downshift;
      shift = 1'b0;
      hold  = 1'b0;
      // first turn of the engine latches the reported gear
      if (w.engine_speed > InitSpeedQ4 && !latched) begin
        latched     = 1'b1;
        req_gear    = w.current_gear;
        last_req_ms = w.now_ms;
      end
      if (latched) begin
        elapsed = w.now_ms - last_req_ms;
        if (elapsed >= wait_ms) begin
          if (omega >= ub && gi < GearCount) begin
            shift = 1'b1;
            if (lat_high) begin
              // revs at the cut point force the upshift, timer left alone
              if (omega >= cutq) req_gear = w.current_gear + 3'd1;
              else hold = 1'b1;
            end else begin
              req_gear    = w.current_gear + 3'd1;
              last_req_ms = w.now_ms;
            end
          end else if ((omega <= lb || down_flag) && gi > 1) begin
            ra  = longint'(ratio_tbl[(gi-2)*RatioW +: RatioW]);
            rb  = longint'(ratio_tbl[(gi-1)*RatioW +: RatioW]);
            thr = ub - longint'(margin_rpm) * Q20;
            if (rb != 0 && omega * ra <= thr * rb) begin
              shift = 1'b1;
              if (lat_high || accel_cut) begin
                hold = 1'b1;
              end else begin
                req_gear    = w.current_gear - 3'd1;
                last_req_ms = w.now_ms;
              end
            end
          end
        end else if (elapsed >= retry_ms && req_gear != w.current_gear) begin
          req_gear = w.current_gear;
          reverts++;
        end
        d.gear_cmd = req_gear;
      end else begin
        d.gear_cmd = w.current_gear;
      end
      d.shift_req      = shift;
      d.cut_shift_req  = hold;
      d.is_initialized = latched;
      shifts += shift;
      held   += hold;
      decisions_due.push_back(d);
    endfunction

    function void diff_field(string field, logic [2:0] want, logic [2:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
      end
    endfunction

    // compares a decision leaving the block with the oldest one owed
    function void check_decision(decision_t got);
      decision_t want;
      if (decisions_due.size() == 0) begin
        errors++;
        $display("%0t: decision with none expected, actual gear %0d shift %0b cut %0b init %0b",
                 $time, got.gear_cmd, got.shift_req, got.cut_shift_req,
                 got.is_initialized);
      end else begin
        want = decisions_due.pop_front();
        checked++;
        diff_field("gear_cmd", want.gear_cmd, got.gear_cmd);
        diff_field("shift_req", want.shift_req, got.shift_req);
        diff_field("cut_shift_req", want.cut_shift_req, got.cut_shift_req);
        diff_field("is_initialized", want.is_initialized, got.is_initialized);
      end
    endfunction

    function int pending();
      return decisions_due.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_index_i;
  logic [CfgW-1:0]           cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [SpeedW-1:0]         engine_speed_i;
  logic [GearW-1:0]          current_gear_i;
  logic [TimeW-1:0]          now_ms_i;
  logic signed [AccelW-1:0]  lateral_accel_i;
  logic signed [AccelW-1:0]  lat_limit_max_i;
  logic signed [AccelW-1:0]  lat_limit_min_i;
  logic signed [AccelW-1:0]  target_long_accel_i;
  logic [SpeedW-1:0]         target_speed_i;
  logic                      predicted_downshift_i;
  logic                      have_trajectory_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic [GearW-1:0]          gear_cmd_o;
  logic                      shift_req_o;
  logic                      cut_shift_req_o;
  logic                      is_initialized_o;

  gear_shift_decider uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .engine_speed_i      (engine_speed_i),
    .current_gear_i      (current_gear_i),
    .now_ms_i            (now_ms_i),
    .lateral_accel_i     (lateral_accel_i),
    .lat_limit_max_i     (lat_limit_max_i),
    .lat_limit_min_i     (lat_limit_min_i),
    .target_long_accel_i (target_long_accel_i),
    .target_speed_i      (target_speed_i),
    .predicted_downshift_i (predicted_downshift_i),
    .have_trajectory_i   (have_trajectory_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .gear_cmd_o          (gear_cmd_o),
    .shift_req_o         (shift_req_o),
    .cut_shift_req_o     (cut_shift_req_o),
    .is_initialized_o    (is_initialized_o)
  );

  gear_decision_board board = new();

  // register values for the next write burst, indexed by register code
  logic [CfgW-1:0]   setting [TblN+1];
  // simulated vehicle: free-running clock and the gear the gearbox reports
  logic [TimeW-1:0]  clock_ms;
  logic [GearW-1:0]  gearbox;
  // idling knobs shared with the result side
  bit                tx_idle_on;
  bit                rx_idle_on;
  int                rx_hold;
  int                words_sent;
  int                settings_used;
  int                cycle_cnt;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // overall watchdog, one count per clock
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles, %0d decisions still owed", cycle_cnt,
               board.pending());
      $display("** gear_shift_decider: FAILED **");
      $finish;
    end
  end

  // watch both handshakes at the rising edge; the result leaving at this edge
  // always belongs to an older word, so it is checked before the new word
  always @(posedge clk_i) begin : watch
    tick_t     w;
    decision_t r;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        r.gear_cmd       = gear_cmd_o;
        r.shift_req      = shift_req_o;
        r.cut_shift_req  = cut_shift_req_o;
        r.is_initialized = is_initialized_o;
        board.check_decision(r);
      end
      if (in_valid_i && !in_stall_o) begin
        w.engine_speed        = engine_speed_i;
        w.current_gear        = current_gear_i;
        w.now_ms              = now_ms_i;
        w.lateral_accel       = lateral_accel_i;
        w.lat_limit_max       = lat_limit_max_i;
        w.lat_limit_min       = lat_limit_min_i;
        w.target_long_accel   = target_long_accel_i;
        w.target_speed        = target_speed_i;
        w.predicted_downshift = predicted_downshift_i;
        w.have_trajectory     = have_trajectory_i;
        board.note_tick(w);
      end
    end
  end

  // result side: per word a random hold-off, or a long one when asked for,
  // then stall low until a result word is taken
  initial begin : result_sink
    int n;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        n       = rx_hold;
        rx_hold = 0;
      end else begin
        n = rx_idle_on ? $urandom_range(0, 16) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // offers one word after an optional gap; entered and left at a falling edge
  task automatic send_word(input tick_t w);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    engine_speed_i        <= w.engine_speed;
    current_gear_i        <= w.current_gear;
    now_ms_i              <= w.now_ms;
    lateral_accel_i       <= w.lateral_accel;
    lat_limit_max_i       <= w.lat_limit_max;
    lat_limit_min_i       <= w.lat_limit_min;
    target_long_accel_i   <= w.target_long_accel;
    target_speed_i        <= w.target_speed;
    predicted_downshift_i <= w.predicted_downshift;
    have_trajectory_i     <= w.have_trajectory;
    in_valid_i            <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  // sender stops and waits for every owed decision, plus a little slack
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // writes all registers back to back from the setting array
  task automatic write_setting();
    for (int i = 0; i <= TblN; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= cfg_idx_e'(i);
      cfg_data_i  <= setting[i];
      board.set_reg(cfg_idx_e'(i), setting[i]);
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    settings_used++;
  endtask

  // stock thresholds and road tables with the given timing
  task automatic load_road_setting(input int wait_v, input int retry_v);
    setting[CfgUpperRpm]  = UpperRpmRst;
    setting[CfgCutRpm]    = CutRpmRst;
    setting[CfgMarginRpm] = MarginRpmRst;
    setting[CfgWaitMs]    = wait_v;
    setting[CfgRetryMs]   = retry_v;
    setting[CfgSafety]    = SafetyRst;
    setting[CfgRatioTbl]  = RoadRatios;
    setting[CfgMinRpmTbl] = RoadMinRpm;
  endtask

  function automatic tick_t tick_of(input int es, input int gear, input logic [31:0] t,
                                    input int ay, input int lmax, input int lmin,
                                    input int ax, input int vt, input bit pred,
                                    input bit traj);
    tick_t w;
    w.engine_speed        = es[SpeedW-1:0];
    w.current_gear        = gear[GearW-1:0];
    w.now_ms              = t;
    w.lateral_accel       = ay[AccelW-1:0];
    w.lat_limit_max       = lmax[AccelW-1:0];
    w.lat_limit_min       = lmin[AccelW-1:0];
    w.target_long_accel   = ax[AccelW-1:0];
    w.target_speed        = vt[SpeedW-1:0];
    w.predicted_downshift = pred;
    w.have_trajectory     = traj;
    return w;
  endfunction

  // next tick of a vehicle whose gearbox mostly follows the commanded gear;
  // revs cluster around the shift thresholds of the active setting
  function automatic tick_t rand_tick();
    tick_t  w;
    int     pick, span, gi;
    longint es, es_ub, es_cut, es_lb;
    span = ((board.wait_ms > board.retry_ms) ? int'(board.wait_ms) : int'(board.retry_ms))
           / 3 + 16;
    pick = $urandom_range(0, 99);
    if (pick < 3) clock_ms = $urandom();
    else clock_ms += $urandom_range(0, span);
    pick = $urandom_range(0, 99);
    if (pick < 5) gearbox = $urandom_range(0, 7);
    else if (pick < 65) gearbox = board.req_gear;
    gi     = (gearbox == 3'd7) ? 6 : int'(gearbox);
    es_ub  = (longint'(board.upper_rpm) * Q20 + 65535) >>> 16;
    es_cut = (longint'(board.cut_rpm) * Q20 + 65535) >>> 16;
    es_lb  = (longint'(board.min_tbl[gi*MinRpmW +: MinRpmW]) * longint'(MinRpmUnit) * Q20)
             >>> 16;
    pick = $urandom_range(0, 99);
    if (pick < 20) es = es_ub + longint'($urandom_range(0, 6)) - 3;
    else if (pick < 30) es = es_cut + longint'($urandom_range(0, 6)) - 3;
    else if (pick < 45) es = es_lb + longint'($urandom_range(0, 6)) - 3;
    else if (pick < 60) es = longint'($urandom_range(0, 32767));
    else es = longint'($urandom_range(int'(es_lb), int'(es_ub > 32767 ? 32767 : es_ub)));
    if (es < 0) es = 0;
    if (es > 32767) es = 32767;
    w.engine_speed        = es[SpeedW-1:0];
    w.current_gear        = gearbox;
    w.now_ms              = clock_ms;
    w.have_trajectory     = ($urandom_range(0, 99) < 85);
    w.predicted_downshift = ($urandom_range(0, 99) < 20);
    w.lat_limit_max       = int'($urandom_range(0, 25600)) - 12800;
    w.lat_limit_min       = int'($urandom_range(0, 25600)) - 12800;
    if ($urandom_range(0, 1) == 0) w.lateral_accel = int'($urandom_range(0, 25600)) - 12800;
    else w.lateral_accel = int'($urandom_range(0, 1200)) - 600;
    w.target_long_accel   = int'($urandom_range(0, 25600)) - 12800;
    w.target_speed        = $urandom_range(0, 25600);
    return w;
  endfunction

  initial begin : stimulus
    logic [TblN*RatioW-1:0]  rtbl;
    logic [TblN*MinRpmW-1:0] mtbl;
    // every input known from time zero
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_index_i           = CfgUpperRpm;
    cfg_data_i            = '0;
    in_valid_i            = 1'b0;
    engine_speed_i        = '0;
    current_gear_i        = '0;
    now_ms_i              = '0;
    lateral_accel_i       = '0;
    lat_limit_max_i       = '0;
    lat_limit_min_i       = '0;
    target_long_accel_i   = '0;
    target_speed_i        = '0;
    predicted_downshift_i = 1'b0;
    have_trajectory_i     = 1'b0;
    tx_idle_on            = 1'b1;
    rx_idle_on            = 1'b1;
    rx_hold               = 0;
    words_sent            = 0;
    settings_used         = 0;
    cycle_cnt             = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // engine not yet started, reset registers: gear passes straight through
    send_word(tick_of(0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_word(tick_of(800, 7, 32'h7FFF_FFFF, -12800, 12800, -12800, 12800, 25600,
                      1'b1, 1'b1));
    send_word(tick_of(700, 3, 5, 300, -40, 90, -5, 300, 1'b1, 1'b0));
    drain();

    // no wait between requests, so the latching tick may shift right away
    load_road_setting(0, 0);
    write_setting();
    // latch in second with revs at the top: upshift on the same tick
    send_word(tick_of(32767, 2, 1000, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // top gear never upshifts
    send_word(tick_of(32767, 6, 1010, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // gear seven at low revs uses the last minimum entry, zero ratio blocks it
    send_word(tick_of(1000, 7, 1020, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // low revs in fourth: plain downshift
    send_word(tick_of(3000, 4, 1030, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    // upshift wanted in a corner below the cut point: held back
    send_word(tick_of(8500, 3, 1040, 1000, 200, -300, 0, 0, 1'b0, 1'b1));
    // same corner above the cut point: upshift forced
    send_word(tick_of(14000, 3, 1050, 1000, 200, -300, 0, 0, 1'b0, 1'b1));
    // predicted downshift that would over-rev
    send_word(tick_of(6000, 4, 1060, 0, 1000, 1000, -100, 0, 1'b1, 1'b1));
    // predicted downshift that fits
    send_word(tick_of(5000, 4, 1070, 0, 1000, 1000, -100, 0, 1'b1, 1'b1));
    // prediction without trajectory is ignored
    send_word(tick_of(5000, 3, 1080, 0, 1000, 1000, -100, 0, 1'b1, 1'b0));
    // accelerating toward a fast target cuts the downshift
    send_word(tick_of(5000, 3, 1090, 0, 1000, 1000, 500, 2000, 1'b1, 1'b1));
    // first gear and neutral never downshift
    send_word(tick_of(5000, 1, 1100, 0, 1000, 1000, 0, 0, 1'b1, 1'b1));
    send_word(tick_of(5000, 0, 1110, 0, 1000, 1000, 0, 0, 1'b1, 1'b1));
    // field extremes, lateral load high and revs at the top
    send_word(tick_of(32767, 5, 1120, -12800, -12800, 12800, -12800, 0, 1'b0, 1'b1));
    drain();

    // retry shorter than wait, requests across the wrap of the clock
    load_road_setting(420, 100);
    write_setting();
    send_word(tick_of(9000, 3, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_word(tick_of(6000, 3, 32'hFFFF_FF32, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_word(tick_of(6000, 3, 32'h0000_0010, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_word(tick_of(9000, 3, 32'h0000_0200, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_word(tick_of(9000, 4, 32'h0000_0201, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    clock_ms = 32'h0000_0201;
    gearbox  = 3'd4;

    // random driving, one register setting per phase
    for (int k = 0; k < 8; k++) begin
      drain();
      case (k)
        0: load_road_setting(420, 150);
        1: begin
          // everything at its floor, tables at their ceiling
          setting[CfgUpperRpm]  = 0;
          setting[CfgCutRpm]    = 0;
          setting[CfgMarginRpm] = 0;
          setting[CfgWaitMs]    = 0;
          setting[CfgRetryMs]   = 0;
          setting[CfgSafety]    = 0;
          setting[CfgRatioTbl]  = {(TblN*RatioW){1'b1}};
          setting[CfgMinRpmTbl] = {(TblN*MinRpmW){1'b1}};
        end
        2: begin
          // everything at its ceiling, road tables
          load_road_setting(16'hFFFF, 16'hFFFF);
          setting[CfgUpperRpm]  = 16383;
          setting[CfgCutRpm]    = 16383;
          setting[CfgMarginRpm] = 4095;
          setting[CfgSafety]    = 255;
        end
        3: load_road_setting(300, 600);
        default: begin
          for (int e = 0; e < TblN; e++) begin
            rtbl[e*RatioW +: RatioW] = ($urandom_range(0, 9) == 0) ? '0 :
                                       RatioW'($urandom_range(60, 511));
            mtbl[e*MinRpmW +: MinRpmW] = MinRpmW'($urandom_range(0, 255));
          end
          setting[CfgUpperRpm]  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) :
                                  $urandom_range(2500, 9000);
          setting[CfgCutRpm]    = $urandom_range(int'(setting[CfgUpperRpm]), 16383);
          setting[CfgMarginRpm] = $urandom_range(0, 4095);
          setting[CfgWaitMs]    = $urandom_range(0, 2000);
          setting[CfgRetryMs]   = $urandom_range(0, 2000);
          setting[CfgSafety]    = $urandom_range(0, 255);
          setting[CfgRatioTbl]  = rtbl;
          setting[CfgMinRpmTbl] = mtbl;
        end
      endcase
      write_setting();
      for (int n = 0; n < PhaseWords; n++) begin
        if (n % 30 == 0) begin
          tx_idle_on = ($urandom_range(0, 2) != 0);
          rx_idle_on = ($urandom_range(0, 2) != 0);
        end
        // long result hold-off while words keep coming back to back
        if ((k == 3 || k == 6) && n == 60) begin
          tx_idle_on = 1'b0;
          rx_hold    = 64;
        end
        // sender waits mid phase for every owed decision
        if (n == PhaseWords / 2) drain();
        send_word(rand_tick());
      end
    end
    drain();

    $display("%0d words over %0d register settings, %0d decisions checked", words_sent,
             settings_used, board.checked);
    $display("%0d shift requests, %0d held back, %0d reverted after retry", board.shifts,
             board.held, board.reverts);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** gear_shift_decider: PASSED **");
    end else begin
      $display("** gear_shift_decider: FAILED **");
    end
    $finish;
  end

endmodule
